// File: rtl/core/bresenham_line_stepper_core_macros.svh
// ----------------------------------------------------------------------------
// bresenham line stepper assertion macros
// assertion wrappers for the line stepper checker
// ----------------------------------------------------------------------------
`ifndef BRESENHAM_LINE_STEPPER_CORE_MACROS_SVH
`define BRESENHAM_LINE_STEPPER_CORE_MACROS_SVH

// checked only outside reset
`define BLS_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// checked on every edge, reset included
`define BLS_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/core/bls_pkg.sv
// ----------------------------------------------------------------------------
// bls_pkg
// shared types, codes and helpers of the line stepper
// ----------------------------------------------------------------------------
package bls_pkg;

  localparam int CFG_BITS   = 9;
  localparam int COLOR_BITS = 16;

  localparam logic CMD_START   = 1'b0;
  localparam logic CMD_ADVANCE = 1'b1;

  localparam logic REG_SCREEN_WIDTH  = 1'b0;
  localparam logic REG_SCREEN_HEIGHT = 1'b1;

  localparam logic [CFG_BITS-1:0] SCREEN_WIDTH_RESET  = 9'd160;
  localparam logic [CFG_BITS-1:0] SCREEN_HEIGHT_RESET = 9'd128;

  typedef logic [COLOR_BITS-1:0] color_t;

  typedef struct packed {
    logic on_screen;
    logic last_pixel;
    logic pixel_valid;
  } pix_flags_t;

  function automatic color_t swap_red_blue(input color_t c);
    return {c[4:0], c[10:5], c[15:11]};
  endfunction

endpackage

// File: rtl/core/bls_cfg_regs.sv
// ----------------------------------------------------------------------------
// bls_cfg_regs
// screen size registers written through the configuration port
// ----------------------------------------------------------------------------
module bls_cfg_regs
  import bls_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic                cfg_index,
  input  logic [CFG_BITS-1:0] cfg_wdata,
  output logic [CFG_BITS-1:0] screen_width,
  output logic [CFG_BITS-1:0] screen_height
);

  logic [CFG_BITS-1:0] width_r;
  logic [CFG_BITS-1:0] height_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= SCREEN_WIDTH_RESET;
      height_r <= SCREEN_HEIGHT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SCREEN_WIDTH:  width_r  <= cfg_wdata;
        REG_SCREEN_HEIGHT: height_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign screen_width  = width_r;
  assign screen_height = height_r;

endmodule

// File: rtl/core/bls_datapath.sv
// ----------------------------------------------------------------------------
// bls_datapath
// line state registers and the single step of the line walk
// ----------------------------------------------------------------------------
module bls_datapath
  import bls_pkg::*;
#(
  parameter int COORD_BITS = 9
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         step_en,
  input  logic                         command,
  input  logic signed [COORD_BITS-1:0] start_x,
  input  logic signed [COORD_BITS-1:0] start_y,
  input  logic signed [COORD_BITS-1:0] end_x,
  input  logic signed [COORD_BITS-1:0] end_y,
  input  color_t                       color,
  input  logic [CFG_BITS-1:0]          screen_width,
  input  logic [CFG_BITS-1:0]          screen_height,
  output logic signed [COORD_BITS-1:0] res_x,
  output logic signed [COORD_BITS-1:0] res_y,
  output color_t                       res_color,
  output pix_flags_t                   res_flags
);

  localparam int DW   = COORD_BITS + 1;
  localparam int EW   = COORD_BITS + 2;
  localparam int SW   = COORD_BITS + 3;
  localparam int CMPW = (COORD_BITS > CFG_BITS) ? COORD_BITS : CFG_BITS;

  logic signed [COORD_BITS-1:0] cur_x_r, cur_y_r, tgt_x_r, tgt_y_r;
  logic signed [COORD_BITS-1:0] cur_x_nxt, cur_y_nxt, tgt_x_nxt, tgt_y_nxt;
  logic [DW-1:0]                dist_x_r, dist_y_r, dist_x_nxt, dist_y_nxt;
  logic                         neg_x_r, neg_y_r, neg_x_nxt, neg_y_nxt;
  logic signed [EW-1:0]         err_r, err_nxt;
  color_t                       color_r, color_nxt;
  logic                         active_r, active_nxt;

  logic signed [DW-1:0] diff_x, diff_y;
  logic [DW-1:0]        abs_x, abs_y;
  logic signed [EW-1:0] err_start;
  logic signed [SW-1:0] e2, dxs, dys, err_adv;
  logic                 move_x, move_y;
  logic                 emit, last, on;

  // start of a line
  always_comb begin
    diff_x    = DW'(end_x) - DW'(start_x);
    diff_y    = DW'(end_y) - DW'(start_y);
    abs_x     = diff_x[DW-1] ? DW'(-diff_x) : DW'(diff_x);
    abs_y     = diff_y[DW-1] ? DW'(-diff_y) : DW'(diff_y);
    err_start = (abs_x > abs_y) ? $signed(EW'(abs_x >> 1)) : -$signed(EW'(abs_y >> 1));
  end

  // one step of an active line
  always_comb begin
    e2      = SW'(err_r);
    dxs     = $signed({2'b00, dist_x_r});
    dys     = $signed({2'b00, dist_y_r});
    move_x  = e2 > -dxs;
    move_y  = e2 < dys;
    err_adv = e2 - (move_x ? dys : SW'(0)) + (move_y ? dxs : SW'(0));
  end

  always_comb begin
    cur_x_nxt  = cur_x_r;
    cur_y_nxt  = cur_y_r;
    tgt_x_nxt  = tgt_x_r;
    tgt_y_nxt  = tgt_y_r;
    dist_x_nxt = dist_x_r;
    dist_y_nxt = dist_y_r;
    neg_x_nxt  = neg_x_r;
    neg_y_nxt  = neg_y_r;
    err_nxt    = err_r;
    color_nxt  = color_r;
    emit       = 1'b0;
    if (command == CMD_START) begin
      cur_x_nxt  = start_x;
      cur_y_nxt  = start_y;
      tgt_x_nxt  = end_x;
      tgt_y_nxt  = end_y;
      dist_x_nxt = abs_x;
      dist_y_nxt = abs_y;
      neg_x_nxt  = diff_x[DW-1] || (diff_x == '0);
      neg_y_nxt  = diff_y[DW-1] || (diff_y == '0);
      err_nxt    = err_start;
      color_nxt  = color;
      emit       = 1'b1;
    end else if (active_r) begin
      if (move_x) begin
        cur_x_nxt = neg_x_r ? cur_x_r - COORD_BITS'(1) : cur_x_r + COORD_BITS'(1);
      end
      if (move_y) begin
        cur_y_nxt = neg_y_r ? cur_y_r - COORD_BITS'(1) : cur_y_r + COORD_BITS'(1);
      end
      err_nxt = EW'(err_adv);
      emit    = 1'b1;
    end
  end

  always_comb begin
    last = (cur_x_nxt == tgt_x_nxt) && (cur_y_nxt == tgt_y_nxt);
    on   = !cur_x_nxt[COORD_BITS-1] && !cur_y_nxt[COORD_BITS-1]
        && (CMPW'($unsigned(cur_x_nxt)) < CMPW'(screen_width))
        && (CMPW'($unsigned(cur_y_nxt)) < CMPW'(screen_height));
    active_nxt = emit ? !last : active_r;
    res_x      = emit ? cur_x_nxt : '0;
    res_y      = emit ? cur_y_nxt : '0;
    res_color  = emit ? swap_red_blue(color_nxt) : '0;
    res_flags.on_screen   = emit && on;
    res_flags.last_pixel  = emit && last;
    res_flags.pixel_valid = emit;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_x_r  <= '0;
      cur_y_r  <= '0;
      tgt_x_r  <= '0;
      tgt_y_r  <= '0;
      dist_x_r <= '0;
      dist_y_r <= '0;
      neg_x_r  <= 1'b0;
      neg_y_r  <= 1'b0;
      err_r    <= '0;
      color_r  <= '0;
      active_r <= 1'b0;
    end else if (step_en) begin
      cur_x_r  <= cur_x_nxt;
      cur_y_r  <= cur_y_nxt;
      tgt_x_r  <= tgt_x_nxt;
      tgt_y_r  <= tgt_y_nxt;
      dist_x_r <= dist_x_nxt;
      dist_y_r <= dist_y_nxt;
      neg_x_r  <= neg_x_nxt;
      neg_y_r  <= neg_y_nxt;
      err_r    <= err_nxt;
      color_r  <= color_nxt;
      active_r <= active_nxt;
    end
  end

endmodule

// File: rtl/core/bls_out_reg.sv
// ----------------------------------------------------------------------------
// bls_out_reg
// result register with valid/ready toward the consumer
// ----------------------------------------------------------------------------
module bls_out_reg
  import bls_pkg::*;
#(
  parameter int COORD_BITS = 9
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         load,
  input  logic signed [COORD_BITS-1:0] res_x,
  input  logic signed [COORD_BITS-1:0] res_y,
  input  color_t                       res_color,
  input  pix_flags_t                   res_flags,
  output logic                         can_load,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic signed [COORD_BITS-1:0] out_pixel_x,
  output logic signed [COORD_BITS-1:0] out_pixel_y,
  output color_t                       out_pixel_color,
  output pix_flags_t                   out_flags
);

  logic                         valid_r, valid_nxt;
  logic signed [COORD_BITS-1:0] x_r, y_r;
  color_t                       color_r;
  pix_flags_t                   flags_r;

  assign can_load  = !valid_r || out_ready;
  assign valid_nxt = load || (valid_r && !out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      x_r     <= res_x;
      y_r     <= res_y;
      color_r <= res_color;
      flags_r <= res_flags;
    end
  end

  assign out_valid       = valid_r;
  assign out_pixel_x     = x_r;
  assign out_pixel_y     = y_r;
  assign out_pixel_color = color_r;
  assign out_flags       = flags_r;

endmodule

// File: rtl/core/bresenham_line_stepper_core.sv
// ----------------------------------------------------------------------------
// bresenham_line_stepper_core
// line pixel generator, one pixel item out for every item in
// the result item is valid in the cycle after its input item is accepted
// throughput: 1 item per cycle, set by the single step datapath into the result register
// the result register frees in the cycle it is taken, so input flows with out_ready high
// reset: synchronous active low, line idle, screen 160 x 128, no result pending
// ----------------------------------------------------------------------------
module bresenham_line_stepper_core
  import bls_pkg::*;
#(
  parameter int COORD_BITS = 9
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic                         cfg_index,
  input  logic [CFG_BITS-1:0]          cfg_wdata,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         in_command,
  input  logic signed [COORD_BITS-1:0] in_start_x,
  input  logic signed [COORD_BITS-1:0] in_start_y,
  input  logic signed [COORD_BITS-1:0] in_end_x,
  input  logic signed [COORD_BITS-1:0] in_end_y,
  input  logic [COLOR_BITS-1:0]        in_color,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic signed [COORD_BITS-1:0] out_pixel_x,
  output logic signed [COORD_BITS-1:0] out_pixel_y,
  output logic [COLOR_BITS-1:0]        out_pixel_color,
  output logic                         out_on_screen,
  output logic                         out_last_pixel,
  output logic                         out_pixel_valid
);

  logic [CFG_BITS-1:0]          screen_width, screen_height;
  logic                         accept;
  logic signed [COORD_BITS-1:0] res_x, res_y;
  color_t                       res_color;
  pix_flags_t                   res_flags, out_flags;

  assign accept = in_valid && in_ready;

  bls_cfg_regs u_cfg_regs (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .screen_width  (screen_width),
    .screen_height (screen_height)
  );

  bls_datapath #(
    .COORD_BITS (COORD_BITS)
  ) u_datapath (
    .clk           (clk),
    .rst_n         (rst_n),
    .step_en       (accept),
    .command       (in_command),
    .start_x       (in_start_x),
    .start_y       (in_start_y),
    .end_x         (in_end_x),
    .end_y         (in_end_y),
    .color         (in_color),
    .screen_width  (screen_width),
    .screen_height (screen_height),
    .res_x         (res_x),
    .res_y         (res_y),
    .res_color     (res_color),
    .res_flags     (res_flags)
  );

  bls_out_reg #(
    .COORD_BITS (COORD_BITS)
  ) u_out_reg (
    .clk             (clk),
    .rst_n           (rst_n),
    .load            (accept),
    .res_x           (res_x),
    .res_y           (res_y),
    .res_color       (res_color),
    .res_flags       (res_flags),
    .can_load        (in_ready),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_pixel_x     (out_pixel_x),
    .out_pixel_y     (out_pixel_y),
    .out_pixel_color (out_pixel_color),
    .out_flags       (out_flags)
  );

  assign out_on_screen   = out_flags.on_screen;
  assign out_last_pixel  = out_flags.last_pixel;
  assign out_pixel_valid = out_flags.pixel_valid;

endmodule

// File: rtl/core/bls_checker.sv
// ----------------------------------------------------------------------------
// bls_checker
// port level checks of the line stepper, bound to the top level
// ----------------------------------------------------------------------------
`include "bresenham_line_stepper_core_macros.svh"

module bls_checker #(
  parameter int COORD_BITS = 9
) (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_ready,
  input logic                  out_valid,
  input logic                  out_ready,
  input logic [COORD_BITS-1:0] out_pixel_x,
  input logic [COORD_BITS-1:0] out_pixel_y,
  input logic [15:0]           out_pixel_color,
  input logic                  out_on_screen,
  input logic                  out_last_pixel,
  input logic                  out_pixel_valid
);

  `BLS_ASSERT_ALWAYS(a_reset_clears_out, clk, !rst_n |=> !out_valid, "result valid after reset")

  `BLS_ASSERT_ALWAYS(a_empty_takes_in, clk, !out_valid |-> in_ready, "input stalled with empty result stage")

  `BLS_ASSERT(a_idle_result_zero, clk, rst_n, out_valid && !out_pixel_valid |-> out_pixel_x == '0 && out_pixel_y == '0 && out_pixel_color == '0 && !out_on_screen && !out_last_pixel, "invalid pixel item not cleared")

  `BLS_ASSERT(a_on_screen_nonneg, clk, rst_n, out_valid && out_on_screen |-> !out_pixel_x[COORD_BITS-1] && !out_pixel_y[COORD_BITS-1], "negative pixel flagged on screen")

  `BLS_ASSERT(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid && $stable(out_pixel_x) && $stable(out_pixel_y) && $stable(out_pixel_color), "stalled result item changed")

endmodule

bind bresenham_line_stepper_core bls_checker #(
  .COORD_BITS (COORD_BITS)
) u_bls_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_ready        (in_ready),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_pixel_x     (out_pixel_x),
  .out_pixel_y     (out_pixel_y),
  .out_pixel_color (out_pixel_color),
  .out_on_screen   (out_on_screen),
  .out_last_pixel  (out_last_pixel),
  .out_pixel_valid (out_pixel_valid)
);

// File: test/line_pixel_check_pkg.sv
// ----------------------------------------------------------------------------
// line pixel scoreboard
// predicts the pixel item of every accepted line stepper item and compares it
// with the pixel items leaving the block, oldest first
// ----------------------------------------------------------------------------
package line_pixel_check_pkg;

  import bls_pkg::*;

  localparam int COORD_BITS = 9;

  typedef logic signed [COORD_BITS-1:0] coord_t;

  typedef struct {
    coord_t x;
    coord_t y;
    color_t color;
    logic   on_flag;
    logic   last_flag;
    logic   valid_flag;
  } pixel_t;

  class line_pixel_scoreboard;

    logic [CFG_BITS-1:0]          width_cfg;
    logic [CFG_BITS-1:0]          height_cfg;
    coord_t                       cur_x;
    coord_t                       cur_y;
    coord_t                       tgt_x;
    coord_t                       tgt_y;
    logic [COORD_BITS:0]          dist_x;
    logic [COORD_BITS:0]          dist_y;
    logic                         step_x_neg;
    logic                         step_y_neg;
    logic signed [COORD_BITS+1:0] err;
    color_t                       line_color;
    logic                         active;
    pixel_t                       expected_pixels[$];
    int                           error_count;

    function new();
      width_cfg   = SCREEN_WIDTH_RESET;
      height_cfg  = SCREEN_HEIGHT_RESET;
      cur_x       = '0;
      cur_y       = '0;
      tgt_x       = '0;
      tgt_y       = '0;
      dist_x      = '0;
      dist_y      = '0;
      step_x_neg  = 1'b0;
      step_y_neg  = 1'b0;
      err         = '0;
      line_color  = '0;
      active      = 1'b0;
      error_count = 0;
    endfunction

    function void set_reg(logic idx, logic [CFG_BITS-1:0] value);
      if (idx == REG_SCREEN_WIDTH) begin
        width_cfg = value;
      end else begin
        height_cfg = value;
      end
    endfunction

    function int pending();
      return expected_pixels.size();
    endfunction

    function pixel_t current_pixel();
      pixel_t p;
      p.x          = cur_x;
      p.y          = cur_y;
      p.color      = {line_color[4:0], line_color[10:5], line_color[15:11]};
      p.last_flag  = (cur_x == tgt_x) && (cur_y == tgt_y);
      p.on_flag    = int'(cur_x) >= 0 && int'(cur_y) >= 0 &&
                     int'(cur_x) < int'(width_cfg) && int'(cur_y) < int'(height_cfg);
      p.valid_flag = 1'b1;
      active       = !p.last_flag;
      return p;
    endfunction

    function void note_item(logic cmd, coord_t x0, coord_t y0, coord_t x1, coord_t y1,
                            color_t c);
      pixel_t p;
      int     dx;
      int     dy;
      int     e2;
      int     next_err;
      if (cmd == CMD_START) begin
        dx         = (int'(x1) > int'(x0)) ? int'(x1) - int'(x0) : int'(x0) - int'(x1);
        dy         = (int'(y1) > int'(y0)) ? int'(y1) - int'(y0) : int'(y0) - int'(y1);
        dist_x     = (COORD_BITS+1)'(dx);
        dist_y     = (COORD_BITS+1)'(dy);
        step_x_neg = !(x0 < x1);
        step_y_neg = !(y0 < y1);
        err        = (COORD_BITS+2)'((dx > dy) ? dx / 2 : -(dy / 2));
        cur_x      = x0;
        cur_y      = y0;
        tgt_x      = x1;
        tgt_y      = y1;
        line_color = c;
        p          = current_pixel();
      end else if (!active) begin
        p.x          = '0;
        p.y          = '0;
        p.color      = '0;
        p.on_flag    = 1'b0;
        p.last_flag  = 1'b0;
        p.valid_flag = 1'b0;
      end else begin
        e2       = int'(err);
        dx       = int'(dist_x);
        dy       = int'(dist_y);
        next_err = e2;
        if (e2 > -dx) begin
          next_err = next_err - dy;
          cur_x    = step_x_neg ? cur_x - 1'b1 : cur_x + 1'b1;
        end
        if (e2 < dy) begin
          next_err = next_err + dx;
          cur_y    = step_y_neg ? cur_y - 1'b1 : cur_y + 1'b1;
        end
        err = (COORD_BITS+2)'(next_err);
        p   = current_pixel();
      end
      expected_pixels.push_back(p);
    endfunction

    function void flag_error(string msg);
      error_count++;
      if (error_count <= 10) begin
        $display("%s", msg);
      end
    endfunction

    function void check_pixel(coord_t x, coord_t y, color_t color, logic on_flag,
                              logic last_flag, logic valid_flag);
      pixel_t exp_p;
      if (expected_pixels.size() == 0) begin
        flag_error($sformatf("unexpected pixel item x=%0d y=%0d color=%h on=%b last=%b valid=%b",
                             x, y, color, on_flag, last_flag, valid_flag));
        return;
      end
      exp_p = expected_pixels.pop_front();
      if (x !== exp_p.x || y !== exp_p.y || color !== exp_p.color ||
          on_flag !== exp_p.on_flag || last_flag !== exp_p.last_flag ||
          valid_flag !== exp_p.valid_flag) begin
        flag_error({
          $sformatf("pixel mismatch: expected x=%0d y=%0d color=%h on=%b last=%b valid=%b",
                    exp_p.x, exp_p.y, exp_p.color, exp_p.on_flag, exp_p.last_flag,
                    exp_p.valid_flag),
          $sformatf(", got x=%0d y=%0d color=%h on=%b last=%b valid=%b",
                    x, y, color, on_flag, last_flag, valid_flag)});
      end
    endfunction

  endclass

endpackage

// File: test/testbench.sv
// ----------------------------------------------------------------------------
// bresenham line stepper testbench
// drives start and advance items with random gaps on both channels, none in the
// last two phases, sets the screen size to its extremes, then random, between
// phases and checks every pixel item against a scoreboard prediction
// ----------------------------------------------------------------------------
module testbench;

  timeunit 1ns;
  timeprecision 1ps;

  import bls_pkg::*;
  import line_pixel_check_pkg::*;

  localparam int STALL_LIMIT = 5000;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                cfg_we = 1'b0;
  logic                cfg_index = REG_SCREEN_WIDTH;
  logic [CFG_BITS-1:0] cfg_wdata = '0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic                in_command = CMD_START;
  coord_t              in_start_x = '0;
  coord_t              in_start_y = '0;
  coord_t              in_end_x = '0;
  coord_t              in_end_y = '0;
  color_t              in_color = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  coord_t              out_pixel_x;
  coord_t              out_pixel_y;
  color_t              out_pixel_color;
  logic                out_on_screen;
  logic                out_last_pixel;
  logic                out_pixel_valid;

  int send_idle_pct = 19;
  int recv_idle_pct = 71;
  int stall_cycles = 0;
  int cur_width = 160;
  int cur_height = 128;

  line_pixel_scoreboard sb;

  bresenham_line_stepper_core #(
    .COORD_BITS(COORD_BITS)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_command(in_command),
    .in_start_x(in_start_x),
    .in_start_y(in_start_y),
    .in_end_x(in_end_x),
    .in_end_y(in_end_y),
    .in_color(in_color),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_pixel_x(out_pixel_x),
    .out_pixel_y(out_pixel_y),
    .out_pixel_color(out_pixel_color),
    .out_on_screen(out_on_screen),
    .out_last_pixel(out_last_pixel),
    .out_pixel_valid(out_pixel_valid)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) begin
        sb.note_item(in_command, in_start_x, in_start_y, in_end_x, in_end_y, in_color);
      end
      if (out_valid && out_ready) begin
        sb.check_pixel(out_pixel_x, out_pixel_y, out_pixel_color, out_on_screen,
                       out_last_pixel, out_pixel_valid);
      end
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
      end
      if (stall_cycles >= STALL_LIMIT) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  function automatic int clip_coord(int v);
    if (v < -256) return -256;
    if (v > 255) return 255;
    return v;
  endfunction

  function automatic int pick_start(int boundary);
    int r;
    r = $urandom_range(99);
    if (r < 30) return int'($urandom_range(511)) - 256;
    if (r < 60) return clip_coord(boundary + int'($urandom_range(8)) - 4);
    if (r < 80) return int'($urandom_range(8)) - 4;
    return int'($urandom_range(255));
  endfunction

  function automatic int pick_end(int from);
    int r;
    int span;
    r = $urandom_range(99);
    if (r < 3) return int'($urandom_range(511)) - 256;
    span = (r < 10) ? 60 : 12;
    return clip_coord(from + int'($urandom_range(2 * span)) - span);
  endfunction

  task automatic send_item(logic cmd, coord_t x0, coord_t y0, coord_t x1, coord_t y1,
                           color_t c);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid   = 1'b1;
    in_command = cmd;
    in_start_x = x0;
    in_start_y = y0;
    in_end_x   = x1;
    in_end_y   = y1;
    in_color   = c;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic start_line(int x0, int y0, int x1, int y1, color_t c);
    send_item(CMD_START, coord_t'(x0), coord_t'(y0), coord_t'(x1), coord_t'(y1), c);
  endtask

  // payload of an advance is ignored, so it is filled with noise
  task automatic advance(int n);
    repeat (n) begin
      send_item(CMD_ADVANCE, coord_t'($urandom), coord_t'($urandom), coord_t'($urandom),
                coord_t'($urandom), color_t'($urandom));
    end
  endtask

  task automatic wait_drained();
    in_valid = 1'b0;
    while (sb.pending() > 0) @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  task automatic write_reg(logic idx, int value);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_wdata = CFG_BITS'(value);
    @(negedge clk);
    cfg_we = 1'b0;
    sb.set_reg(idx, CFG_BITS'(value));
    if (idx == REG_SCREEN_WIDTH) begin
      cur_width = value;
    end else begin
      cur_height = value;
    end
  endtask

  task automatic run_random(int items);
    int sent;
    int x0;
    int y0;
    int x1;
    int y1;
    int dx;
    int dy;
    int steps;
    int n;
    int r;
    sent = 0;
    while (sent < items) begin
      x0 = pick_start(cur_width);
      y0 = pick_start(cur_height);
      x1 = pick_end(x0);
      y1 = pick_end(y0);
      dx = (x1 > x0) ? x1 - x0 : x0 - x1;
      dy = (y1 > y0) ? y1 - y0 : y0 - y1;
      steps = (dx > dy) ? dx : dy;
      r = $urandom_range(99);
      if (r < 80) begin
        n = steps;
      end else if (r < 90) begin
        n = $urandom_range(steps);
      end else begin
        n = steps + $urandom_range(3, 1);
      end
      start_line(x0, y0, x1, y1, color_t'($urandom));
      advance(n);
      sent += n + 1;
    end
  endtask

  initial begin
    sb = new();
    repeat (2) @(negedge clk);
    rst_n = 1'b1;

    // directed part with the reset screen size
    advance(1);
    start_line(0, 0, 0, 0, 16'hffff);
    advance(1);
    start_line(-256, -256, 255, 255, 16'hf800);
    advance(2);
    // abandons the line above
    start_line(255, -256, -256, 255, 16'h07e0);
    advance(1);
    // crosses the right and bottom screen edges, then idles
    start_line(158, 126, 161, 130, 16'h001f);
    advance(5);
    start_line(2, 1, -3, -1, 16'h0000);
    advance(6);

    for (int phase = 0; phase < 6; phase++) begin
      wait_drained();
      case (phase)
        0: begin
          write_reg(REG_SCREEN_WIDTH, 256);
          write_reg(REG_SCREEN_HEIGHT, 256);
        end
        1: begin
          write_reg(REG_SCREEN_WIDTH, 1);
          write_reg(REG_SCREEN_HEIGHT, 1);
        end
        2: begin
          write_reg(REG_SCREEN_WIDTH, 256);
          write_reg(REG_SCREEN_HEIGHT, 1);
          send_idle_pct = 71;
          recv_idle_pct = 19;
        end
        3: begin
          write_reg(REG_SCREEN_WIDTH, 1);
          write_reg(REG_SCREEN_HEIGHT, 256);
        end
        default: begin
          write_reg(REG_SCREEN_WIDTH, $urandom_range(256, 1));
          write_reg(REG_SCREEN_HEIGHT, $urandom_range(256, 1));
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      run_random(290);
    end

    wait_drained();
    if (sb.error_count == 0 && sb.pending() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
